/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 8;
    localparam int PRIO_BITS_DEF = 8;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// A result word is registered and appears in the cycle after its word is
// accepted. Throughput: one word per cycle while in_ready is high; every cell
// compares with the new priority in parallel; moving entries shift one place.
// Reset: clears the fill count and the output valid flag; cell contents are
// left as they are and are never read before being written.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [ID_BITS-1:0]   proc_id,
    input  wire logic [PRIO_BITS-1:0] prio,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [ID_BITS-1:0]        out_id,
    output logic [PRIO_BITS-1:0]      out_prio,
    output logic [CNT_W-1:0]          occupancy
);

    logic                 in_fire;
    logic                 is_full;
    logic                 is_empty;
    cell_ctrl_t           ctrl;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 valid_reg;
    logic                 valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [ID_BITS-1:0]   out_id_next;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [PRIO_BITS-1:0] out_prio_next;
    logic [CNT_W-1:0]     occ_reg;

    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     keep;
    logic [ID_BITS-1:0]   cell_id   [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];

    // Take a new word whenever the result register is free or being drained
    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Drop an enqueue on a full queue and a dequeue on an empty one
    assign ctrl.enq = in_fire && (opcode == OP_ENQ) && !is_full;
    assign ctrl.deq = in_fire && (opcode == OP_DEQ) && !is_empty;

    // Row of cells, head at cell 0. On insert a cell keeps its entry, takes
    // the new one if its left neighbor keeps, or takes the left neighbor's
    // entry. On removal every cell takes its right neighbor's entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 l_keep;
        logic [ID_BITS-1:0]   l_id;
        logic [PRIO_BITS-1:0] l_prio;
        logic [ID_BITS-1:0]   r_id;
        logic [PRIO_BITS-1:0] r_prio;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign l_keep = 1'b1;
            assign l_id   = proc_id;
            assign l_prio = prio;
        end
        else
        begin : g_mid
            assign l_keep = keep[i-1];
            assign l_id   = cell_id[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_id   = cell_id[i];
            assign r_prio = cell_prio[i];
        end
        else
        begin : g_body
            assign r_id   = cell_id[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_id     (proc_id),
            .new_prio   (prio),
            .occupied   (occ[i]),
            .left_keep  (l_keep),
            .left_id    (l_id),
            .left_prio  (l_prio),
            .right_id   (r_id),
            .right_prio (r_prio),
            .keep       (keep[i]),
            .cell_id    (cell_id[i]),
            .cell_prio  (cell_prio[i])
        );
    end

    // Fill count and result word
    always_comb
    begin
        count_next    = count_reg;
        valid_next    = valid_reg;
        status_next   = status_reg;
        out_id_next   = '0;
        out_prio_next = '0;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next    = count_reg - CNT_W'(1);
            out_id_next   = cell_id[0];
            out_prio_next = cell_prio[0];
        end

        if (in_fire)
        begin
            valid_next = 1'b1;
            if (opcode == OP_ENQ)
            begin
                status_next = is_full ? ST_FULL : ST_OK;
            end
            else
            begin
                status_next = is_empty ? ST_EMPTY : ST_OK;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            valid_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    // Load the result payload only with a new word; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_id_reg   <= out_id_next;
            out_prio_reg <= out_prio_next;
            occ_reg      <= count_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_prio  = out_prio_reg;
    assign occupancy = occ_reg;

    // Fill count never passes the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // An accepted enqueue on a full queue reports full and leaves count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (opcode == OP_ENQ) && is_full
        |=> (status_reg == ST_FULL) && (count_reg == CNT_W'(DEPTH)))
        else $error("enqueue on full queue not dropped");

    // An empty report always carries zero occupancy
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (status_reg == ST_EMPTY) |-> (occ_reg == '0))
        else $error("empty status with nonzero occupancy");

    // Head two entries stay in ascending priority order
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        occ[1] |-> (cell_prio[0] <= cell_prio[1]))
        else $error("head entries out of order");

endmodule

`default_nettype wire

/* rtl/spq_cell.sv */
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [ID_BITS-1:0]   new_id,
    input  wire logic [PRIO_BITS-1:0] new_prio,
    input  wire logic                 occupied,
    input  wire logic                 left_keep,
    input  wire logic [ID_BITS-1:0]   left_id,
    input  wire logic [PRIO_BITS-1:0] left_prio,
    input  wire logic [ID_BITS-1:0]   right_id,
    input  wire logic [PRIO_BITS-1:0] right_prio,
    output logic                      keep,
    output logic [ID_BITS-1:0]        cell_id,
    output logic [PRIO_BITS-1:0]      cell_prio
);

    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // Entry stays put on insert when it is at or below the new priority
    assign keep      = occupied && (prio_reg <= new_prio);
    assign cell_id   = id_reg;
    assign cell_prio = prio_reg;

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.enq && !keep)
        begin
            if (left_keep)
            begin
                id_next   = new_id;
                prio_next = new_prio;
            end
            else
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
        end
        else if (ctrl.deq)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCC_W       = $clog2(DEPTH_DEF + 1);
    localparam int RANDOM_WORDS = 725;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_WORD = 150;
    localparam int CYCLE_LIMIT  = 100000;

    // One result word as the block reports it
    typedef struct packed {
        logic [1:0]       st;
        logic [7:0]       id;
        logic [7:0]       pr;
        logic [OCC_W-1:0] occ;
    } spq_result_t;

    // One row of the directed table; typed rows carry their answer
    typedef struct packed {
        logic        op;
        logic [7:0]  id;
        logic [7:0]  pr;
        logic        typed;
        spq_result_t want;
    } dir_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PATTERN
    } rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             opcode;
    logic [7:0]       proc_id;
    logic [7:0]       prio;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [7:0]       out_id;
    logic [7:0]       out_prio;
    logic [OCC_W-1:0] occupancy;

    // Side channel that travels with the offered word: a typed answer, if any
    logic        row_typed;
    spq_result_t row_want;

    // Mirror of the queue contents, head at slot 0
    logic [7:0] mirror_id   [DEPTH_DEF];
    logic [7:0] mirror_prio [DEPTH_DEF];
    int         mirror_fill;

    spq_result_t pending_results [$];
    dir_row_t    dir_rows [$];

    int  errors        = 0;
    int  words_in      = 0;
    int  results_seen  = 0;
    int  full_rejects  = 0;
    int  empty_pops    = 0;
    int  peak_occ      = 0;
    int  burst_left    = 0;
    int  cycle_count   = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;

    sorted_priority_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .proc_id   (proc_id),
        .prio      (prio),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .occupancy (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one accepted word to the mirror and return the word the block owes
    function automatic spq_result_t queue_apply(input logic op, input logic [7:0] id,
                                                input logic [7:0] pr);
        spq_result_t r;
        int          pos;
        int          k;
        r = '0;
        r.st = ST_OK;
        if (op == OP_ENQ)
        begin
            if (mirror_fill >= DEPTH_DEF)
                r.st = ST_FULL;
            else
            begin
                // insert behind every entry of equal or lower value: ties stay FIFO
                pos = 0;
                while (pos < mirror_fill && mirror_prio[pos] <= pr)
                    pos++;
                for (k = mirror_fill; k > pos; k--)
                begin
                    mirror_id[k]   = mirror_id[k - 1];
                    mirror_prio[k] = mirror_prio[k - 1];
                end
                mirror_id[pos]   = id;
                mirror_prio[pos] = pr;
                mirror_fill++;
            end
        end
        else
        begin
            if (mirror_fill == 0)
                r.st = ST_EMPTY;
            else
            begin
                r.id = mirror_id[0];
                r.pr = mirror_prio[0];
                for (k = 1; k < mirror_fill; k++)
                begin
                    mirror_id[k - 1]   = mirror_id[k];
                    mirror_prio[k - 1] = mirror_prio[k];
                end
                mirror_fill--;
            end
        end
        r.occ = OCC_W'(mirror_fill);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] id, input logic [7:0] pr,
                           input logic typed, input logic [1:0] st, input logic [7:0] oid,
                           input logic [7:0] opr, input int occ);
        dir_row_t row;
        row.op       = op;
        row.id       = id;
        row.pr       = pr;
        row.typed    = typed;
        row.want.st  = st;
        row.want.id  = oid;
        row.want.pr  = opr;
        row.want.occ = OCC_W'(occ);
        dir_rows.push_back(row);
    endtask

    // Offer one word, inserting a random gap between bursts, and hold it until accepted
    task automatic offer_word(input logic op, input logic [7:0] id, input logic [7:0] pr,
                              input logic typed, input spq_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        opcode    <= op;
        proc_id   <= id;
        prio      <= pr;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Scoreboard: retire result words first, then log the word accepted at this edge
    always @(posedge clk)
    begin
        spq_result_t got;
        spq_result_t want;
        spq_result_t predicted;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.st  = status;
                got.id  = out_id;
                got.pr  = out_prio;
                got.occ = occupancy;
                results_seen++;
                if (int'(got.occ) > peak_occ)
                    peak_occ = int'(got.occ);
                if (got.st == ST_FULL)
                    full_rejects++;
                if (got.st == ST_EMPTY)
                    empty_pops++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, %s %0d id %0d prio %0d occ %0d",
                             $realtime, "status", got.st, got.id, got.pr, got.occ);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.st, got.st);
                    check_field("out_id", want.id, got.id);
                    check_field("out_prio", want.pr, got.pr);
                    check_field("occupancy", want.occ, got.occ);
                end
            end
            if (in_valid && in_ready)
            begin
                // always advance the mirror; typed rows override its answer
                predicted = queue_apply(opcode, proc_id, prio);
                pending_results.push_back(row_typed ? row_want : predicted);
                words_in++;
            end
        end
    end

    // Receiver: switch stall pattern now and then; honor one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       rx_tick;
        mode      = RX_OPEN;
        mode_left = 0;
        rx_tick   = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                // drop ready and count the hold-off here while the sender keeps pushing
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            rx_tick++;
            case (mode)
                RX_OPEN:    out_ready <= 1'b1;
                RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:  out_ready <= ($urandom_range(0, 99) < 85);
                default:    out_ready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d result words outstanding",
                     $realtime, pending_results.size());
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    initial
    begin
        int          phase_left;
        int          enq_pct;
        logic        op;
        logic [7:0]  id;
        logic [7:0]  pr;
        spq_result_t none;

        none        = '0;
        mirror_fill = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_ENQ;
        proc_id   <= '0;
        prio      <= '0;
        row_typed <= 1'b0;
        row_want  <= '0;

        // Directed table: empty pop, extremes, FIFO ties, fill to the brim, full reject
        add_row(OP_DEQ, 8'hAA, 8'h55, 1'b1, ST_EMPTY, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hFF, 8'hFF, 1'b1, ST_OK,    8'h00, 8'h00, 1);
        add_row(OP_ENQ, 8'h00, 8'h00, 1'b1, ST_OK,    8'h00, 8'h00, 2);
        add_row(OP_DEQ, 8'h5A, 8'hA5, 1'b1, ST_OK,    8'h00, 8'h00, 1);
        add_row(OP_DEQ, 8'h00, 8'h00, 1'b1, ST_OK,    8'hFF, 8'hFF, 0);
        add_row(OP_DEQ, 8'hFF, 8'hFF, 1'b1, ST_EMPTY, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h11, 8'h80, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h22, 8'h80, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h33, 8'h80, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h01, 8'h7F, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hFE, 8'h81, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h44, 8'h00, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h55, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h5A, 8'h80, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hA5, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h66, 8'hFE, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h77, 8'h40, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h88, 8'hC0, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'h99, 8'h20, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hAA, 8'h10, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hBB, 8'h08, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hCC, 8'h04, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_ENQ, 8'hDD, 8'h00, 1'b1, ST_FULL, 8'h00, 8'h00, DEPTH_DEF);
        add_row(OP_DEQ, 8'h00, 8'h00, 1'b0, ST_OK, 8'h00, 8'h00, 0);
        add_row(OP_DEQ, 8'hFF, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_word(dir_rows[i].op, dir_rows[i].id, dir_rows[i].pr,
                       dir_rows[i].typed, dir_rows[i].want);

        // Random part: phases of skewed enqueue ratio drive the queue to full and to empty
        phase_left = 0;
        enq_pct    = 50;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       enq_pct = 95;
                    1:       enq_pct = 5;
                    2:       enq_pct = 75;
                    3:       enq_pct = 25;
                    default: enq_pct = 50;
                endcase
                phase_left = $urandom_range(20, 70);
            end
            phase_left--;
            if (n == HOLD_AT_WORD)
            begin
                hold_req   <= 1'b1;
                burst_left = 100;
            end
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            id = 8'($urandom_range(0, 255));
            // two narrow bands at the ends of the range force plenty of ties
            case ($urandom_range(0, 3))
                0:       pr = 8'($urandom_range(0, 3));
                1:       pr = 8'($urandom_range(252, 255));
                default: pr = 8'($urandom_range(0, 255));
            endcase
            offer_word(op, id, pr, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d words in, %0d results out, peak occupancy %0d.",
                 words_in, results_seen, peak_occ);
        $display("Rejected enqueues on full queue: %0d, dequeues on empty queue: %0d.",
                 full_rejects, empty_pops);
        if (errors == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule

`default_nettype wire
